// ===== hdl/csvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

  // field widths of the channels
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FCNT_W  = 5;
  localparam int unsigned FIELD_W = 4;

  // default depth of the held whitespace store
  localparam int unsigned HELD_SPACE_DEPTH_DEF = 32;

  // delimiter codes
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;

  // field count register
  localparam logic [FCNT_W-1:0] FIELD_COUNT_RESET = 5'd8;
  localparam logic [FCNT_W-1:0] MAX_FIELDS        = 5'd16;

  // one result transaction
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic [FIELD_W-1:0] field_number;
    logic               field_done;
    logic               line_done;
    logic               line_good;
    logic               run_last;
  } res_t;

  // ascii whitespace: tab, line feed, vertical tab, form feed, return, space
  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

endpackage

`default_nettype wire

// ===== hdl/csvt_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface csvt_in_if
  import csvt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] line_byte;
  logic              last_in_line;

  modport source (output valid, output line_byte, output last_in_line, input ready);
  modport sink (input valid, input line_byte, input last_in_line, output ready);
endinterface

`default_nettype wire

// ===== hdl/csvt_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface csvt_out_if
  import csvt_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               byte_valid;
  logic [FIELD_W-1:0] field_number;
  logic               field_done;
  logic               line_done;
  logic               line_good;
  logic               run_last;

  modport source (
    output valid, output out_byte, output byte_valid, output field_number,
    output field_done, output line_done, output line_good, output run_last,
    input ready
  );
  modport sink (
    input valid, input out_byte, input byte_valid, input field_number,
    input field_done, input line_done, input line_good, input run_last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/csvt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csvt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/csv_line_tokenizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one byte per cycle while no held whitespace or line-end verdict is pending
// and the output is not stalled. A byte releasing held whitespace passes the flush, byte
// and, at line end, verdict states; a line-end content byte or field end gives its result
// then the verdict. The store has one read port, so released bytes leave one a cycle unless
// output stalls. The first result is registered on acceptance, or in the flush state.
// Reset (synchronous, rst_n low): line state cleared, field_count 8; store left as is.

module csv_line_tokenizer_core
  import csvt_pkg::*;
#(
  parameter int unsigned HELD_SPACE_DEPTH = HELD_SPACE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  csvt_in_if.sink                in_chan,
  csvt_out_if.source             out_chan,
  input  wire logic              cfg_we,
  input  wire logic [FCNT_W-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(HELD_SPACE_DEPTH);
  localparam int unsigned CW = $clog2(HELD_SPACE_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(HELD_SPACE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_FLUSH, S_PRIM, S_VERD} state_t;

  state_t             state_r, state_nxt;
  logic [FCNT_W-1:0]  fc_r, fc_nxt;
  logic               quoting_r, quoting_nxt;
  logic               look_r, look_nxt;
  logic [FIELD_W-1:0] fld_r, fld_nxt;
  logic               seen_r, seen_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               failed_r, failed_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      flast_r, flast_nxt;
  logic [BYTE_W-1:0]  pbyte_r, pbyte_nxt;
  logic [FIELD_W-1:0] pfld_r, pfld_nxt;
  logic               pverd_r, pverd_nxt;
  logic               vgood_r, vgood_nxt;
  logic [FIELD_W-1:0] vfld_r, vfld_nxt;
  res_t               res_r, res_nxt;
  logic               ovalid_r, ovalid_nxt;

  // byte decode results
  logic               in_fire, out_free;
  logic [BYTE_W-1:0]  c;
  logic               c_quote, c_comma, c_space;
  logic               q_d, la_d, seen_d, fail_d;
  logic [FIELD_W-1:0] fld_d;
  logic [CW-1:0]      cnt_d;
  logic               do_cont, do_comma, do_prim, prim_is_byte, do_write, do_flush;
  logic               good_d;
  logic [FCNT_W-1:0]  eff_cnt;
  logic [CW-1:0]      cnt_m1;
  logic [AW-1:0]      raddr;
  logic [BYTE_W-1:0]  rdata;
  res_t               r_prim, r_verd, r_flush;

  assign c        = in_chan.line_byte;
  assign c_quote  = (c == CH_QUOTE);
  assign c_comma  = (c == CH_COMMA);
  assign c_space  = is_space(c);
  assign out_free = !ovalid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign eff_cnt  = (fc_r > MAX_FIELDS) ? MAX_FIELDS : fc_r;
  assign cnt_m1   = cnt_r - CW'(1);

  // next line state for the offered byte
  always_comb begin
    q_d          = quoting_r;
    la_d         = look_r;
    fld_d        = fld_r;
    seen_d       = seen_r;
    cnt_d        = cnt_r;
    fail_d       = failed_r;
    do_cont      = 1'b0;
    do_comma     = 1'b0;
    do_prim      = 1'b0;
    prim_is_byte = 1'b0;
    do_write     = 1'b0;
    do_flush     = 1'b0;
    if (!failed_r) begin
      if (look_r && c_quote) begin
        // doubled quote inside quotes
        la_d    = 1'b0;
        do_cont = 1'b1;
      end else begin
        if (look_r) begin
          la_d = 1'b0;
          q_d  = 1'b0;
        end
        if (c_quote) begin
          if (q_d) begin
            la_d = 1'b1;
          end else begin
            q_d = 1'b1;
          end
        end else if (c_comma && !q_d) begin
          do_comma = 1'b1;
        end else begin
          do_cont = 1'b1;
        end
      end
    end
    // content byte: hold trailing whitespace or release it
    if (do_cont) begin
      if (c_space) begin
        if (seen_r) begin
          if (cnt_r == CNT_FULL) begin
            fail_d = 1'b1;
          end else begin
            do_write = 1'b1;
            cnt_d    = cnt_r + CW'(1);
          end
        end
      end else begin
        do_flush     = (cnt_r != '0);
        do_prim      = 1'b1;
        prim_is_byte = 1'b1;
        cnt_d        = '0;
        seen_d       = 1'b1;
      end
    end
    // field end
    if (do_comma) begin
      if (!seen_r || ({1'b0, fld_r} + 5'd1) >= eff_cnt) begin
        fail_d = 1'b1;
      end else begin
        do_prim = 1'b1;
        fld_d   = fld_r + 4'd1;
        seen_d  = 1'b0;
        cnt_d   = '0;
      end
    end
    // verdict; a pending quote at line end closes quoting
    good_d = !fail_d && !(q_d && !la_d) && seen_d && (({1'b0, fld_d} + 5'd1) == eff_cnt);
  end

  // result words
  always_comb begin
    r_prim              = '0;
    r_prim.out_byte     = prim_is_byte ? c : '0;
    r_prim.byte_valid   = prim_is_byte;
    r_prim.field_number = fld_r;
    r_prim.field_done   = !prim_is_byte;
    r_prim.run_last     = !in_chan.last_in_line;

    r_verd              = '0;
    r_verd.field_number = (state_r == S_IDLE) ? fld_d : vfld_r;
    r_verd.field_done   = (state_r == S_IDLE) ? good_d : vgood_r;
    r_verd.line_done    = 1'b1;
    r_verd.line_good    = (state_r == S_IDLE) ? good_d : vgood_r;
    r_verd.run_last     = 1'b1;

    r_flush              = '0;
    r_flush.out_byte     = rdata;
    r_flush.byte_valid   = 1'b1;
    r_flush.field_number = pfld_r;
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    fc_nxt      = cfg_we ? cfg_wdata : fc_r;
    quoting_nxt = quoting_r;
    look_nxt    = look_r;
    fld_nxt     = fld_r;
    seen_nxt    = seen_r;
    cnt_nxt     = cnt_r;
    failed_nxt  = failed_r;
    idx_nxt     = idx_r;
    flast_nxt   = flast_r;
    pbyte_nxt   = pbyte_r;
    pfld_nxt    = pfld_r;
    pverd_nxt   = pverd_r;
    vgood_nxt   = vgood_r;
    vfld_nxt    = vfld_r;
    res_nxt     = res_r;
    ovalid_nxt  = ovalid_r && !out_chan.ready;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // line state follows the byte, or clears at line end
          if (in_chan.last_in_line) begin
            quoting_nxt = 1'b0;
            look_nxt    = 1'b0;
            fld_nxt     = '0;
            seen_nxt    = 1'b0;
            cnt_nxt     = '0;
            failed_nxt  = 1'b0;
          end else begin
            quoting_nxt = q_d;
            look_nxt    = la_d;
            fld_nxt     = fld_d;
            seen_nxt    = seen_d;
            cnt_nxt     = cnt_d;
            failed_nxt  = fail_d;
          end
          pbyte_nxt = c;
          pfld_nxt  = fld_r;
          pverd_nxt = in_chan.last_in_line;
          vgood_nxt = good_d;
          vfld_nxt  = fld_d;
          if (do_flush) begin
            idx_nxt   = '0;
            flast_nxt = cnt_m1[AW-1:0];
            state_nxt = S_FLUSH;
          end else if (do_prim) begin
            res_nxt    = r_prim;
            ovalid_nxt = 1'b1;
            if (in_chan.last_in_line) begin
              state_nxt = S_VERD;
            end
          end else if (in_chan.last_in_line) begin
            res_nxt    = r_verd;
            ovalid_nxt = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        // release held whitespace, one store read a cycle while the output is free
        if (out_free) begin
          res_nxt    = r_flush;
          ovalid_nxt = 1'b1;
          if (idx_r == flast_r) begin
            state_nxt = S_PRIM;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      S_PRIM: begin
        if (out_free) begin
          res_nxt              = '0;
          res_nxt.out_byte     = pbyte_r;
          res_nxt.byte_valid   = 1'b1;
          res_nxt.field_number = pfld_r;
          res_nxt.run_last     = !pverd_r;
          ovalid_nxt           = 1'b1;
          state_nxt            = pverd_r ? S_VERD : S_IDLE;
        end
      end
      S_VERD: begin
        if (out_free) begin
          res_nxt    = r_verd;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // read address runs one ahead while the output register drains
  always_comb begin
    if (state_r == S_FLUSH) begin
      raddr = out_free ? (idx_r + AW'(1)) : idx_r;
    end else begin
      raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fc_r      <= FIELD_COUNT_RESET;
      quoting_r <= 1'b0;
      look_r    <= 1'b0;
      fld_r     <= '0;
      seen_r    <= 1'b0;
      cnt_r     <= '0;
      failed_r  <= 1'b0;
      idx_r     <= '0;
      flast_r   <= '0;
      pbyte_r   <= '0;
      pfld_r    <= '0;
      pverd_r   <= 1'b0;
      vgood_r   <= 1'b0;
      vfld_r    <= '0;
      res_r     <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fc_r      <= fc_nxt;
      quoting_r <= quoting_nxt;
      look_r    <= look_nxt;
      fld_r     <= fld_nxt;
      seen_r    <= seen_nxt;
      cnt_r     <= cnt_nxt;
      failed_r  <= failed_nxt;
      idx_r     <= idx_nxt;
      flast_r   <= flast_nxt;
      pbyte_r   <= pbyte_nxt;
      pfld_r    <= pfld_nxt;
      pverd_r   <= pverd_nxt;
      vgood_r   <= vgood_nxt;
      vfld_r    <= vfld_nxt;
      res_r     <= res_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  // held whitespace store
  csvt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HELD_SPACE_DEPTH)
  ) u_held (
    .clk   (clk),
    .we    (in_fire && do_write),
    .waddr (cnt_r[AW-1:0]),
    .wdata (c),
    .raddr (raddr),
    .rdata (rdata)
  );

  // result transaction
  assign out_chan.valid        = ovalid_r;
  assign out_chan.out_byte     = res_r.out_byte;
  assign out_chan.byte_valid   = res_r.byte_valid;
  assign out_chan.field_number = res_r.field_number;
  assign out_chan.field_done   = res_r.field_done;
  assign out_chan.line_done    = res_r.line_done;
  assign out_chan.line_good    = res_r.line_good;
  assign out_chan.run_last     = res_r.run_last;

endmodule

`default_nettype wire
